// ----- design/crcdle_pkg.sv -----
// Shared constants, types and CRC functions for the CRC-16 DLE packet framer.
package crcdle_pkg;

  // Framing control codes.
  localparam logic [7:0] SOH_CODE = 8'h01;
  localparam logic [7:0] EOT_CODE = 8'h04;
  localparam logic [7:0] DLE_CODE = 8'h10;

  // One input byte expands to at most eight line bytes.
  localparam int MAX_OUT = 8;
  localparam int IDX_W   = $clog2(MAX_OUT);
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Line bytes caused by one input byte, slot 0 goes out first.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    closes;
  } byte_seq_t;

  // Nibble table for polynomial 0x1021.
  function automatic logic [15:0] nib_tab(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'h0: val = 16'h0000;
      4'h1: val = 16'h1021;
      4'h2: val = 16'h2042;
      4'h3: val = 16'h3063;
      4'h4: val = 16'h4084;
      4'h5: val = 16'h50A5;
      4'h6: val = 16'h60C6;
      4'h7: val = 16'h70E7;
      4'h8: val = 16'h8108;
      4'h9: val = 16'h9129;
      4'hA: val = 16'hA14A;
      4'hB: val = 16'hB16B;
      4'hC: val = 16'hC18C;
      4'hD: val = 16'hD1AD;
      4'hE: val = 16'hE1CE;
      default: val = 16'hF1EF;
    endcase
    return val;
  endfunction

  // One nibble step of the CRC.
  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
    return nib_tab(crc[15:12] ^ nib) ^ {crc[11:0], 4'h0};
  endfunction

  // One byte of the CRC, high nibble first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    return crc_nibble(crc_nibble(crc, b[7:4]), b[3:0]);
  endfunction

  // Bytes that need a DLE in front of them.
  function automatic logic needs_escape(input logic [7:0] b);
    return (b == SOH_CODE) || (b == EOT_CODE) || (b == DLE_CODE);
  endfunction

endpackage

// ----- design/crc_dle_packet_framer_top.sv -----
// Top level of the CRC-16 DLE packet framer.
// Path: an accepted item is held in the pending register, then loaded into the output shifter.
// Throughput: one line byte per cycle while out_ready is high; an item causes 1 to 8
// line bytes, sent over the single output byte port. One further item waits in a
// pending register while the output drains; after that the input stalls.
// Reset: synchronous rst clears the CRC to zero, closes the frame and empties both stages.
module crc_dle_packet_framer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end
);
  import crcdle_pkg::*;

  logic [15:0]      crc_accum;
  logic             in_frame;
  logic [15:0]      crc_accum_next;
  byte_seq_t        enc_seq;
  logic             pend_valid;
  byte_seq_t        pend_seq;
  logic [MAX_OUT-1:0][7:0] sh_bytes;
  logic [CNT_W-1:0] sh_cnt;
  logic             sh_closes;
  logic             in_fire;
  logic             out_fire;
  logic             sh_free;
  logic             pend_move;

  // Byte expansion and CRC step for the item on the input port.
  crcdle_encode u_encode (
    .data_byte  (data_byte),
    .open_frame (first_byte | ~in_frame),
    .last_byte  (last_byte),
    .crc_in     (crc_accum),
    .seq        (enc_seq),
    .crc_out    (crc_accum_next)
  );

  // Handshake control between pending register and output shifter.
  assign out_valid = (sh_cnt != '0);
  assign out_fire  = out_valid & out_ready;
  assign sh_free   = (sh_cnt == '0) | ((sh_cnt == CNT_W'(1)) & out_ready);
  assign pend_move = pend_valid & sh_free;
  assign in_ready  = ~pend_valid | pend_move;
  assign in_fire   = in_valid & in_ready;

  // Output fields come from the head of the shifter.
  assign out_byte  = sh_bytes[0];
  assign run_last  = (sh_cnt == CNT_W'(1));
  assign frame_end = (sh_cnt == CNT_W'(1)) & sh_closes;

  // Frame state and CRC advance on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= '0;
      in_frame  <= 1'b0;
    end else if (in_fire) begin
      crc_accum <= crc_accum_next;
      in_frame  <= ~last_byte;
    end
  end

  // Pending register holds one expanded item.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_seq <= enc_seq;
    end
  end

  // Output shifter: loads a pending item or moves one byte per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_cnt <= '0;
    end else if (pend_move) begin
      sh_cnt <= pend_seq.count;
    end else if (out_fire) begin
      sh_cnt <= sh_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      sh_bytes  <= pend_seq.bytes;
      sh_closes <= pend_seq.closes;
    end else if (out_fire) begin
      sh_bytes[MAX_OUT-2:0] <= sh_bytes[MAX_OUT-1:1];
      sh_bytes[MAX_OUT-1]   <= '0;
    end
  end

endmodule

// ----- design/crcdle_encode.sv -----
// Expands one payload byte into its framed line bytes and advances the CRC.
module crcdle_encode (
  input  logic [7:0]             data_byte,
  input  logic                   open_frame,
  input  logic                   last_byte,
  input  logic [15:0]            crc_in,
  output crcdle_pkg::byte_seq_t  seq,
  output logic [15:0]            crc_out
);
  import crcdle_pkg::*;

  logic [15:0]      crc_upd;
  logic [CNT_W-1:0] idx;

  // CRC over the payload byte; a new frame starts the CRC from zero.
  assign crc_upd = crc_byte(open_frame ? 16'h0000 : crc_in, data_byte);
  assign crc_out = last_byte ? 16'h0000 : crc_upd;

  // Pack in order: SOH if opening, data, then CRC low, CRC high, EOT if last; a DLE before any byte needing escape.
  always_comb begin
    seq = '0;
    idx = '0;
    if (open_frame) begin
      seq.bytes[idx[IDX_W-1:0]] = SOH_CODE;
      idx = idx + 1'b1;
    end
    if (needs_escape(data_byte)) begin
      seq.bytes[idx[IDX_W-1:0]] = DLE_CODE;
      idx = idx + 1'b1;
    end
    seq.bytes[idx[IDX_W-1:0]] = data_byte;
    idx = idx + 1'b1;
    if (last_byte) begin
      if (needs_escape(crc_upd[7:0])) begin
        seq.bytes[idx[IDX_W-1:0]] = DLE_CODE;
        idx = idx + 1'b1;
      end
      seq.bytes[idx[IDX_W-1:0]] = crc_upd[7:0];
      idx = idx + 1'b1;
      if (needs_escape(crc_upd[15:8])) begin
        seq.bytes[idx[IDX_W-1:0]] = DLE_CODE;
        idx = idx + 1'b1;
      end
      seq.bytes[idx[IDX_W-1:0]] = crc_upd[15:8];
      idx = idx + 1'b1;
      seq.bytes[idx[IDX_W-1:0]] = EOT_CODE;
      idx = idx + 1'b1;
    end
    seq.count  = idx;
    seq.closes = last_byte;
  end

endmodule

// ----- tb/crc_dle_packet_framer_checker.sv -----
// Checker for the CRC-16 DLE packet framer: predicts the line bytes and compares them.
module crc_dle_packet_framer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       frame_end,
  output int         fail_count,
  output int         bytes_due,
  output int         bytes_checked,
  output int         frames_closed
);
  import crcdle_pkg::*;

  // One line byte as the framer should send it.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } line_byte_t;

  line_byte_t  line_bytes_due[$];
  logic [15:0] payload_crc;
  logic        frame_open;

  initial begin
    fail_count    = 0;
    bytes_due     = 0;
    bytes_checked = 0;
    frames_closed = 0;
    payload_crc   = '0;
    frame_open    = 1'b0;
  end

  // Bit-serial XMODEM CRC update, MSB first.
  function automatic logic [15:0] xmodem_crc_update(input logic [15:0] crc,
                                                    input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  task automatic queue_line_byte(input logic [7:0] b, input logic closing);
    line_byte_t entry;
    entry.line_byte = b;
    entry.run_last  = 1'b0;
    entry.frame_end = closing;
    line_bytes_due.push_back(entry);
  endtask

  // Control codes on the line are escaped with a DLE.
  task automatic queue_stuffed_byte(input logic [7:0] b);
    if (b == SOH_CODE || b == EOT_CODE || b == DLE_CODE) begin
      queue_line_byte(DLE_CODE, 1'b0);
    end
    queue_line_byte(b, 1'b0);
  endtask

  // Works out the line bytes caused by one accepted payload byte.
  task automatic frame_payload_byte(input logic [7:0] d, input logic f, input logic l);
    if (f || !frame_open) begin
      queue_line_byte(SOH_CODE, 1'b0);
      payload_crc = '0;
      frame_open  = 1'b1;
    end
    queue_stuffed_byte(d);
    payload_crc = xmodem_crc_update(payload_crc, d);
    if (l) begin
      queue_stuffed_byte(payload_crc[7:0]);
      queue_stuffed_byte(payload_crc[15:8]);
      queue_line_byte(EOT_CODE, 1'b1);
      payload_crc = '0;
      frame_open  = 1'b0;
    end
    line_bytes_due[line_bytes_due.size()-1].run_last = 1'b1;
  endtask

  // Watch both channels on every rising edge.
  always @(posedge clk) begin
    line_byte_t want;
    if (rst) begin
      line_bytes_due.delete();
      payload_crc = '0;
      frame_open  = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_payload_byte(data_byte, first_byte, last_byte);
      end
      if (out_valid && out_ready) begin
        if (line_bytes_due.size() == 0) begin
          $error("unexpected line byte transfer: out_byte %h", out_byte);
          fail_count++;
        end else begin
          want = line_bytes_due.pop_front();
          bytes_checked++;
          if (want.frame_end) begin
            frames_closed++;
          end
          if (out_byte !== want.line_byte) begin
            $error("out_byte: expected %h, got %h", want.line_byte, out_byte);
            fail_count++;
          end
          if (run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last);
            fail_count++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, frame_end);
            fail_count++;
          end
        end
      end
    end
    bytes_due = line_bytes_due.size();
  end

endmodule

// ----- tb/tb_crc_dle_packet_framer_top.sv -----
// Testbench top for the CRC-16 DLE packet framer: clock, reset, stimulus and verdict.
module tb_crc_dle_packet_framer_top;
  import crcdle_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 45;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] data_byte  = 8'h00;
  logic       first_byte = 1'b0;
  logic       last_byte  = 1'b0;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  int fail_count;
  int bytes_due;
  int bytes_checked;
  int frames_closed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;
  int bytes_sent    = 0;

  crc_dle_packet_framer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

  crc_dle_packet_framer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .frame_end     (frame_end),
    .fail_count    (fail_count),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_crc_dle_packet_framer_top: errors");
      $finish;
    end
  end

  // The line receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Payload bytes lean toward the control codes so stuffing is hit often.
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(9))
      0:       b = SOH_CODE;
      1:       b = EOT_CODE;
      2:       b = DLE_CODE;
      3:       b = 8'h00;
      4:       b = 8'hFF;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Offers one payload byte and returns at the falling edge after its transfer.
  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    first_byte <= f;
    last_byte  <= l;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted line byte has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (bytes_due != 0);
  endtask

  initial begin
    int phase;
    int items;
    int pkt_len;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: frame opened without a first flag, stuffing of every
    // control code, one-byte packets, CRC bytes that need escaping and an
    // abandoned frame.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(SOH_CODE, 1'b0, 1'b0);
    send_byte(EOT_CODE, 1'b0, 1'b0);
    send_byte(DLE_CODE, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(DLE_CODE, 1'b1, 1'b1);
    // CRC high byte is DLE.
    send_byte(SOH_CODE, 1'b1, 1'b1);
    // CRC low byte is SOH, DLE and EOT in turn.
    send_byte(8'h23, 1'b1, 1'b1);
    send_byte(8'h11, 1'b1, 1'b1);
    send_byte(8'h8C, 1'b1, 1'b1);
    // A new first byte abandons the open frame.
    send_byte(8'hA5, 1'b1, 1'b0);
    send_byte(EOT_CODE, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // Last byte with no frame open opens and closes a frame.
    send_byte(8'h3C, 1'b0, 1'b1);
    wait_drained();

    // Random packets under three stall patterns.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          // Loose byte with arbitrary frame flags.
          send_byte(pick_payload(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          items++;
        end else begin
          pkt_len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
          for (int k = 0; k < pkt_len; k++) begin
            send_byte(pick_payload(), k == 0, k == pkt_len - 1);
            items++;
          end
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d payload bytes under three stall patterns; checked %0d line bytes",
             bytes_sent, bytes_checked);
    $display("and %0d closed frames, including stuffed CRC bytes and abandoned frames.",
             frames_closed);
    if (fail_count == 0) begin
      $display("tb_crc_dle_packet_framer_top: clean");
    end else begin
      $display("tb_crc_dle_packet_framer_top: errors");
    end
    $finish;
  end

endmodule
